// ===== src/photometric_interaction_row_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Photometric interaction row unit: assertion macros
// Clocked implication checks; compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef PHOTOMETRIC_INTERACTION_ROW_UNIT_ASSERT_SVH
`define PHOTOMETRIC_INTERACTION_ROW_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PIR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pir assertion failed");
// next-cycle implication
`define PIR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pir assertion failed");
`else
`define PIR_ASSERT_IMP(label, clk, rst, ante, cons)
`define PIR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/pir_pkg.sv =====
// ---------------------------------------------------------------------------
// Photometric interaction row package
// Field types, fixed-point widths, register codes and output saturation.
// ---------------------------------------------------------------------------
package pir_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 12;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 8;
  localparam int OUT_W     = 48;

  localparam int SUM_W     = 10;
  localparam int GRAD_W    = 11;
  localparam int DIFF_W    = 25;
  localparam int NPROD_W   = 49;
  localparam int NORM_SHIFT = 16;
  localparam int NORM_W    = NPROD_W - NORM_SHIFT;
  localparam int INT_W     = 35;

  localparam int LO_W      = 17;
  localparam int C_L_W     = LO_W + INT_W;
  localparam int C_H_W     = NORM_W - LO_W + INT_W;
  localparam int PART_W    = NORM_W + INT_W;
  localparam int ACC_W     = PART_W + 1;

  localparam int SLO_W     = 35;
  localparam int B_LL_W    = LO_W + SLO_W + 1;
  localparam int B_LH_W    = LO_W + 1 + ACC_W - SLO_W;
  localparam int B_HL_W    = NORM_W - LO_W + SLO_W;
  localparam int B_HH_W    = NORM_W - LO_W + ACC_W - SLO_W;
  localparam int XSL_W     = NORM_W + SLO_W + 1;
  localparam int XSH_W     = NORM_W + ACC_W - SLO_W;
  localparam int U_W       = 70;
  localparam int TOT_W     = 103;
  localparam int TR_SHIFT  = 8;
  localparam int ROT_SHIFT = 40;
  localparam int ONE_SHIFT = 32;
  localparam int SAT_IN_W  = 64;

  localparam logic signed [NPROD_W-1:0] NORM_HALF = NPROD_W'(64'd1 << (NORM_SHIFT - 1));
  localparam logic signed [U_W-1:0]     TR_HALF   = U_W'(64'd1 << (TR_SHIFT - 1));
  localparam logic signed [U_W-1:0]     ROT_HALF  = U_W'(64'd1 << (ROT_SHIFT - 1));
  localparam logic signed [OUT_W-1:0]   OUT_MAX   = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic signed [OUT_W-1:0]   OUT_MIN   = {1'b1, {(OUT_W - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X     = 8'd0,
    REG_FOCAL_Y     = 8'd1,
    REG_CENTER_X    = 8'd2,
    REG_CENTER_Y    = 8'd3,
    REG_INV_FOCAL_X = 8'd4,
    REG_INV_FOCAL_Y = 8'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] focal_x;
    logic [CFG_W-1:0] focal_y;
    logic [CFG_W-1:0] center_x;
    logic [CFG_W-1:0] center_y;
    logic [CFG_W-1:0] inv_focal_x;
    logic [CFG_W-1:0] inv_focal_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    focal_x:     24'd136637,
    focal_y:     24'd136814,
    center_x:    24'd124503,
    center_y:    24'd64448,
    inv_focal_x: 24'd31434,
    inv_focal_y: 24'd31393
  };

  typedef struct packed {
    logic [PIX_W-1:0]   pix_top_left;
    logic [PIX_W-1:0]   pix_top_mid;
    logic [PIX_W-1:0]   pix_top_right;
    logic [PIX_W-1:0]   pix_mid_left;
    logic [PIX_W-1:0]   pix_center;
    logic [PIX_W-1:0]   pix_mid_right;
    logic [PIX_W-1:0]   pix_bot_left;
    logic [PIX_W-1:0]   pix_bot_mid;
    logic [PIX_W-1:0]   pix_bot_right;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row_index;
  } win_item_t;

  typedef struct packed {
    logic                    is_valid;
    logic signed [OUT_W-1:0] l_tx;
    logic signed [OUT_W-1:0] l_ty;
    logic signed [OUT_W-1:0] l_tz;
    logic signed [OUT_W-1:0] l_rx;
    logic signed [OUT_W-1:0] l_ry;
    logic signed [OUT_W-1:0] l_rz;
  } row_item_t;

  typedef struct packed {
    logic                     live;
    logic signed [INT_W-1:0]  ix;
    logic signed [INT_W-1:0]  iy;
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
  } coord_t;

  typedef struct packed {
    logic                     live;
    logic signed [INT_W-1:0]  ix;
    logic signed [INT_W-1:0]  iy;
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [ACC_W-1:0]  s;
    logic signed [ACC_W-1:0]  r;
  } cross_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_IN_W-1:0] v);
    logic signed [OUT_W-1:0] res;
    if (&v[SAT_IN_W-1:OUT_W-1] || ~|v[SAT_IN_W-1:OUT_W-1]) begin
      res = v[OUT_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      res = OUT_MIN;
    end else begin
      res = OUT_MAX;
    end
    return res;
  endfunction

endpackage

// ===== src/pir_if.sv =====
// ---------------------------------------------------------------------------
// Photometric interaction row channels
// Valid/ready channels for windows, rows and register writes.
// ---------------------------------------------------------------------------
interface pir_win_if import pir_pkg::*; ();
  logic      valid;
  logic      ready;
  win_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pir_row_if import pir_pkg::*; ();
  logic      valid;
  logic      ready;
  row_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pir_cfg_if import pir_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [CFG_W-1:0]     wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

// ===== src/photometric_interaction_row_unit.sv =====
// ---------------------------------------------------------------------------
// Photometric interaction row unit
// Pipeline: 3 front, 3 product and 5 output stages from window transfer to row.
// Throughput: one window per cycle; a full stage holds only while the next stage holds.
// Reset: rst empties every stage and reloads the camera registers with their defaults.
// ---------------------------------------------------------------------------
module photometric_interaction_row_unit import pir_pkg::*; #(
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  logic      clk,
  input  logic      rst,
  pir_cfg_if.sink   cfg,
  pir_win_if.sink   win,
  pir_row_if.source irow
);

  cfg_t   regs;
  logic   fc_valid, fc_ready;
  coord_t fc_data;
  logic   cb_valid, cb_ready;
  cross_t cb_data;

  pir_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  pir_front #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .in_valid  (win.valid),
    .in_ready  (win.ready),
    .in_data   (win.data),
    .out_valid (fc_valid),
    .out_ready (fc_ready),
    .out_data  (fc_data)
  );

  pir_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fc_valid),
    .in_ready  (fc_ready),
    .in_data   (fc_data),
    .out_valid (cb_valid),
    .out_ready (cb_ready),
    .out_data  (cb_data)
  );

  pir_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cb_valid),
    .in_ready  (cb_ready),
    .in_data   (cb_data),
    .out_valid (irow.valid),
    .out_ready (irow.ready),
    .out_data  (irow.data)
  );

endmodule

// ===== src/pir_cfg.sv =====
// ---------------------------------------------------------------------------
// Photometric interaction row: camera registers
// Holds focal lengths, principal point and reciprocal focals.
// ---------------------------------------------------------------------------
module pir_cfg import pir_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pir_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.idx)
        REG_FOCAL_X:     regs.focal_x     <= cfg.wdata;
        REG_FOCAL_Y:     regs.focal_y     <= cfg.wdata;
        REG_CENTER_X:    regs.center_x    <= cfg.wdata;
        REG_CENTER_Y:    regs.center_y    <= cfg.wdata;
        REG_INV_FOCAL_X: regs.inv_focal_x <= cfg.wdata;
        REG_INV_FOCAL_Y: regs.inv_focal_y <= cfg.wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/pir_front.sv =====
// ---------------------------------------------------------------------------
// Photometric interaction row: front stages
// Sobel gradients, focal scaling and normalized coordinates, three stages.
// ---------------------------------------------------------------------------
module pir_front import pir_pkg::*; #(
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      regs,
  input  logic      in_valid,
  output logic      in_ready,
  input  win_item_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output coord_t    out_data
);

  localparam int NS = 3;
  localparam logic [31:0] COORD_LIM = 32'(MAX_IMAGE_DIM - 1);

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  logic [COORD_W-1:0]       u_cl, v_cl;
  logic [SUM_W-1:0]         gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [DIFF_W-1:0] du, dv;
  logic signed [NPROD_W-1:0] pu_r, pv_r;

  logic signed [GRAD_W-1:0]  f1_gx, f1_gy;
  logic signed [DIFF_W-1:0]  f1_du, f1_dv;
  logic                      f1_live;
  logic signed [INT_W-1:0]   f2_ix, f2_iy;
  logic signed [NPROD_W-1:0] f2_pu, f2_pv;
  logic                      f2_live;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_comb begin
    u_cl = (32'(in_data.column) > COORD_LIM) ? COORD_LIM[COORD_W-1:0] : in_data.column;
    v_cl = (32'(in_data.row_index) > COORD_LIM) ? COORD_LIM[COORD_W-1:0] : in_data.row_index;
    gx_pos = SUM_W'(in_data.pix_top_right) + {1'b0, in_data.pix_mid_right, 1'b0}
           + SUM_W'(in_data.pix_bot_right);
    gx_neg = SUM_W'(in_data.pix_top_left) + {1'b0, in_data.pix_mid_left, 1'b0}
           + SUM_W'(in_data.pix_bot_left);
    gy_pos = SUM_W'(in_data.pix_bot_left) + {1'b0, in_data.pix_bot_mid, 1'b0}
           + SUM_W'(in_data.pix_bot_right);
    gy_neg = SUM_W'(in_data.pix_top_left) + {1'b0, in_data.pix_top_mid, 1'b0}
           + SUM_W'(in_data.pix_top_right);
    gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    du = $signed({5'd0, u_cl, 8'd0}) - $signed({1'b0, regs.center_x});
    dv = $signed({5'd0, v_cl, 8'd0}) - $signed({1'b0, regs.center_y});
    pu_r = f2_pu + NORM_HALF;
    pv_r = f2_pv + NORM_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= (k == 0) ? in_valid : v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      f1_gx   <= gx;
      f1_gy   <= gy;
      f1_du   <= du;
      f1_dv   <= dv;
      f1_live <= (in_data.pix_center != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      f2_ix   <= f1_gx * $signed({1'b0, regs.focal_x});
      f2_iy   <= f1_gy * $signed({1'b0, regs.focal_y});
      f2_pu   <= f1_du * $signed({1'b0, regs.inv_focal_x});
      f2_pv   <= f1_dv * $signed({1'b0, regs.inv_focal_y});
      f2_live <= f1_live;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_data.live <= f2_live;
      out_data.ix   <= f2_ix;
      out_data.iy   <= f2_iy;
      out_data.x    <= $signed(pu_r[NPROD_W-1:NORM_SHIFT]);
      out_data.y    <= $signed(pv_r[NPROD_W-1:NORM_SHIFT]);
    end
  end

endmodule

// ===== src/pir_cross.sv =====
// ---------------------------------------------------------------------------
// Photometric interaction row: gradient-coordinate products
// Forms x*Ix + y*Iy and x*Iy - y*Ix from split partial products.
// ---------------------------------------------------------------------------
module pir_cross import pir_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output cross_t out_data
);

  localparam int NS = 3;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  logic signed [C_L_W-1:0]  c1_xil, c1_yjl, c1_xjl, c1_yil;
  logic signed [C_H_W-1:0]  c1_xih, c1_yjh, c1_xjh, c1_yih;
  coord_t                   c1_c;
  logic signed [PART_W-1:0] c2_a, c2_b, c2_p, c2_q;
  coord_t                   c2_c;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= (k == 0) ? in_valid : v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c1_xil <= $signed({1'b0, in_data.x[LO_W-1:0]}) * in_data.ix;
      c1_xih <= $signed(in_data.x[NORM_W-1:LO_W]) * in_data.ix;
      c1_yjl <= $signed({1'b0, in_data.y[LO_W-1:0]}) * in_data.iy;
      c1_yjh <= $signed(in_data.y[NORM_W-1:LO_W]) * in_data.iy;
      c1_xjl <= $signed({1'b0, in_data.x[LO_W-1:0]}) * in_data.iy;
      c1_xjh <= $signed(in_data.x[NORM_W-1:LO_W]) * in_data.iy;
      c1_yil <= $signed({1'b0, in_data.y[LO_W-1:0]}) * in_data.ix;
      c1_yih <= $signed(in_data.y[NORM_W-1:LO_W]) * in_data.ix;
      c1_c   <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c2_a <= PART_W'($signed({c1_xih, {LO_W{1'b0}}})) + PART_W'(c1_xil);
      c2_b <= PART_W'($signed({c1_yjh, {LO_W{1'b0}}})) + PART_W'(c1_yjl);
      c2_p <= PART_W'($signed({c1_xjh, {LO_W{1'b0}}})) + PART_W'(c1_xjl);
      c2_q <= PART_W'($signed({c1_yih, {LO_W{1'b0}}})) + PART_W'(c1_yil);
      c2_c <= c1_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_data.live <= c2_c.live;
      out_data.ix   <= c2_c.ix;
      out_data.iy   <= c2_c.iy;
      out_data.x    <= c2_c.x;
      out_data.y    <= c2_c.y;
      out_data.s    <= ACC_W'(c2_a) + ACC_W'(c2_b);
      out_data.r    <= ACC_W'(c2_p) - ACC_W'(c2_q);
    end
  end

endmodule

// ===== src/pir_back.sv =====
// ---------------------------------------------------------------------------
// Photometric interaction row: rotation terms and output stage
// Rounds and saturates four of the six entries (tz, rz, rx, ry); rotation terms in five stages.
// ---------------------------------------------------------------------------
`include "photometric_interaction_row_unit_assert.svh"

module pir_back import pir_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cross_t    in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output row_item_t out_data
);

  localparam int NS = 5;

  typedef struct packed {
    logic                    live;
    logic signed [OUT_W-1:0] tx;
    logic signed [OUT_W-1:0] ty;
    logic signed [OUT_W-1:0] tz;
    logic signed [OUT_W-1:0] rz;
  } side_t;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  logic signed [U_W-1:0] ntz, nrz;

  logic signed [B_LL_W-1:0] b1_xll, b1_yll;
  logic signed [B_LH_W-1:0] b1_xlh, b1_ylh;
  logic signed [B_HL_W-1:0] b1_xhl, b1_yhl;
  logic signed [B_HH_W-1:0] b1_xhh, b1_yhh;
  logic signed [INT_W-1:0]  b1_ix, b1_iy, b2_ix, b2_iy;
  side_t                    b1_side, b2_side, b3_side, b4_side;
  logic signed [XSL_W-1:0]  b2_xsl, b2_ysl;
  logic signed [XSH_W-1:0]  b2_xsh, b2_ysh, b3_xsh, b3_ysh;
  logic signed [U_W-1:0]    b3_ury, b3_urx;
  logic signed [TOT_W-1:0]  b4_try, b4_trx;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_comb begin
    ntz = TR_HALF - U_W'(in_data.s);
    nrz = TR_HALF + U_W'(in_data.r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= (k == 0) ? in_valid : v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      b1_xll <= $signed({1'b0, in_data.x[LO_W-1:0]}) * $signed({1'b0, in_data.s[SLO_W-1:0]});
      b1_xlh <= $signed({1'b0, in_data.x[LO_W-1:0]}) * $signed(in_data.s[ACC_W-1:SLO_W]);
      b1_xhl <= $signed(in_data.x[NORM_W-1:LO_W]) * $signed({1'b0, in_data.s[SLO_W-1:0]});
      b1_xhh <= $signed(in_data.x[NORM_W-1:LO_W]) * $signed(in_data.s[ACC_W-1:SLO_W]);
      b1_yll <= $signed({1'b0, in_data.y[LO_W-1:0]}) * $signed({1'b0, in_data.s[SLO_W-1:0]});
      b1_ylh <= $signed({1'b0, in_data.y[LO_W-1:0]}) * $signed(in_data.s[ACC_W-1:SLO_W]);
      b1_yhl <= $signed(in_data.y[NORM_W-1:LO_W]) * $signed({1'b0, in_data.s[SLO_W-1:0]});
      b1_yhh <= $signed(in_data.y[NORM_W-1:LO_W]) * $signed(in_data.s[ACC_W-1:SLO_W]);
      b1_ix  <= in_data.ix;
      b1_iy  <= in_data.iy;
      b1_side.live <= in_data.live;
      b1_side.tx   <= OUT_W'($signed({in_data.ix, {TR_SHIFT{1'b0}}}));
      b1_side.ty   <= OUT_W'($signed({in_data.iy, {TR_SHIFT{1'b0}}}));
      b1_side.tz   <= sat_out(SAT_IN_W'($signed(ntz[U_W-1:TR_SHIFT])));
      b1_side.rz   <= sat_out(SAT_IN_W'($signed(nrz[U_W-1:TR_SHIFT])));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b2_xsl  <= XSL_W'($signed({b1_xhl, {LO_W{1'b0}}})) + XSL_W'(b1_xll);
      b2_xsh  <= XSH_W'($signed({b1_xhh, {LO_W{1'b0}}})) + XSH_W'(b1_xlh);
      b2_ysl  <= XSL_W'($signed({b1_yhl, {LO_W{1'b0}}})) + XSL_W'(b1_yll);
      b2_ysh  <= XSH_W'($signed({b1_yhh, {LO_W{1'b0}}})) + XSH_W'(b1_ylh);
      b2_ix   <= b1_ix;
      b2_iy   <= b1_iy;
      b2_side <= b1_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      b3_ury  <= U_W'(b2_xsl) + U_W'($signed({b2_ix, {ONE_SHIFT{1'b0}}})) + ROT_HALF;
      b3_urx  <= ROT_HALF - U_W'(b2_ysl) - U_W'($signed({b2_iy, {ONE_SHIFT{1'b0}}}));
      b3_xsh  <= b2_xsh;
      b3_ysh  <= b2_ysh;
      b3_side <= b2_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      b4_try  <= TOT_W'($signed({b3_xsh, {SLO_W{1'b0}}})) + TOT_W'(b3_ury);
      b4_trx  <= TOT_W'(b3_urx) - TOT_W'($signed({b3_ysh, {SLO_W{1'b0}}}));
      b4_side <= b3_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      out_data.is_valid <= b4_side.live;
      out_data.l_tx <= b4_side.live ? b4_side.tx : '0;
      out_data.l_ty <= b4_side.live ? b4_side.ty : '0;
      out_data.l_tz <= b4_side.live ? b4_side.tz : '0;
      out_data.l_rz <= b4_side.live ? b4_side.rz : '0;
      out_data.l_rx <= b4_side.live
                     ? sat_out(SAT_IN_W'($signed(b4_trx[TOT_W-1:ROT_SHIFT]))) : '0;
      out_data.l_ry <= b4_side.live
                     ? sat_out(SAT_IN_W'($signed(b4_try[TOT_W-1:ROT_SHIFT]))) : '0;
    end
  end

  `PIR_ASSERT_IMP(a_masked_zero, clk, rst, out_valid && !out_data.is_valid,
    out_data.l_tx == '0 && out_data.l_ty == '0 && out_data.l_tz == '0 &&
    out_data.l_rx == '0 && out_data.l_ry == '0 && out_data.l_rz == '0)
  `PIR_ASSERT_IMP(a_trans_low_byte, clk, rst, out_valid,
    out_data.l_tx[TR_SHIFT-1:0] == '0 && out_data.l_ty[TR_SHIFT-1:0] == '0)
  `PIR_ASSERT_IMP(a_room_when_drained, clk, rst, !v[NS-1], in_ready)
  `PIR_ASSERT_NXT(a_drain_on_transfer, clk, rst, out_valid && out_ready && !v[NS-2],
    !out_valid)

endmodule
